// ===== rtl/touch_auto_repeat_clock_control_macros.svh =====
// Assertion macros for the touch auto-repeat clock control RTL.
`ifndef TOUCH_AUTO_REPEAT_CLOCK_CONTROL_MACROS_SVH
`define TOUCH_AUTO_REPEAT_CLOCK_CONTROL_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TRAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/trac_pkg.sv =====
// Types and constants for the touch auto-repeat clock control block.
package trac_pkg;

  // Controller states, coded as reported on state_code.
  typedef enum logic [2:0] {
    ST_INIT     = 3'd0,
    ST_NEVER    = 3'd1,
    ST_WAIT     = 3'd2,
    ST_SETTLE   = 3'd3,
    ST_AUTO     = 3'd4,
    ST_RATE_RUN = 3'd5,
    ST_RATE_EXP = 3'd6
  } state_e;

  localparam int unsigned SettleW = 8;
  localparam int unsigned AutoW   = 10;
  localparam int unsigned RateW   = 8;
  localparam int unsigned SubSecW = 10;

  localparam int unsigned AddrW = 4;

  // Register byte addresses.
  localparam logic [AddrW-1:0] ADDR_SETTLE_TICKS = 4'h0;
  localparam logic [AddrW-1:0] ADDR_AUTO_DELAY   = 4'h4;
  localparam logic [AddrW-1:0] ADDR_REPEAT_TICKS = 4'h8;
  localparam logic [AddrW-1:0] ADDR_TICKS_PER_S  = 4'hC;

  // Register reset values.
  localparam logic [SettleW-1:0] RST_SETTLE_TICKS = 8'd1;
  localparam logic [AutoW-1:0]   RST_AUTO_DELAY   = 10'd10;
  localparam logic [RateW-1:0]   RST_REPEAT_TICKS = 8'd2;
  localparam logic [SubSecW-1:0] RST_TICKS_PER_S  = 10'd20;

  typedef struct packed {
    logic [SettleW-1:0] settle_ticks;
    logic [AutoW-1:0]   auto_delay_ticks;
    logic [RateW-1:0]   repeat_ticks;
    logic [SubSecW-1:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    logic   inc_dec_pulse;
    logic   clear_touch_pulse;
    logic   advance_second;
    state_e state_code;
  } result_t;

endpackage

// ===== rtl/trac_cfg_regs.sv =====
// APB configuration registers for the touch auto-repeat clock control block.
module trac_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [trac_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output trac_pkg::cfg_t            cfg_o
);

  trac_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode the write request.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr)
        trac_pkg::ADDR_SETTLE_TICKS:
          cfg_d.settle_ticks = pwdata[trac_pkg::SettleW-1:0];
        trac_pkg::ADDR_AUTO_DELAY:
          cfg_d.auto_delay_ticks = pwdata[trac_pkg::AutoW-1:0];
        trac_pkg::ADDR_REPEAT_TICKS:
          cfg_d.repeat_ticks = pwdata[trac_pkg::RateW-1:0];
        trac_pkg::ADDR_TICKS_PER_S:
          cfg_d.ticks_per_second = pwdata[trac_pkg::SubSecW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks     <= trac_pkg::RST_SETTLE_TICKS;
      cfg_q.auto_delay_ticks <= trac_pkg::RST_AUTO_DELAY;
      cfg_q.repeat_ticks     <= trac_pkg::RST_REPEAT_TICKS;
      cfg_q.ticks_per_second <= trac_pkg::RST_TICKS_PER_S;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register, zero-extended.
  always_comb begin
    unique case (paddr)
      trac_pkg::ADDR_SETTLE_TICKS:
        prdata = {{(32-trac_pkg::SettleW){1'b0}}, cfg_q.settle_ticks};
      trac_pkg::ADDR_AUTO_DELAY:
        prdata = {{(32-trac_pkg::AutoW){1'b0}}, cfg_q.auto_delay_ticks};
      trac_pkg::ADDR_REPEAT_TICKS:
        prdata = {{(32-trac_pkg::RateW){1'b0}}, cfg_q.repeat_ticks};
      trac_pkg::ADDR_TICKS_PER_S:
        prdata = {{(32-trac_pkg::SubSecW){1'b0}}, cfg_q.ticks_per_second};
      default:
        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/trac_ctrl_core.sv =====
// Touch state machine, hold counters and sub-second counter.
`include "touch_auto_repeat_clock_control_macros.svh"

module trac_ctrl_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              touched_i,
  input  trac_pkg::cfg_t    cfg_i,
  output trac_pkg::result_t result_o
);

  trac_pkg::state_e             state_q, state_d;
  logic [trac_pkg::SettleW-1:0] settle_q, settle_d;
  logic [trac_pkg::AutoW-1:0]   auto_q, auto_d;
  logic [trac_pkg::RateW-1:0]   rate_q, rate_d;
  logic [trac_pkg::SubSecW-1:0] subsec_q, subsec_d;
  logic [trac_pkg::SubSecW:0]   subsec_inc;
  logic                         inc_dec, clr, adv;

  // Pick the next state and its pulses.
  always_comb begin
    inc_dec = 1'b0;
    clr     = 1'b0;
    state_d = state_q;
    unique case (state_q)
      trac_pkg::ST_NEVER, trac_pkg::ST_WAIT: begin
        if (touched_i) begin
          clr     = 1'b1;
          state_d = trac_pkg::ST_SETTLE;
        end
      end
      trac_pkg::ST_SETTLE: begin
        if (settle_q == cfg_i.settle_ticks) begin
          if (touched_i) begin
            clr     = 1'b1;
            state_d = trac_pkg::ST_AUTO;
          end else begin
            inc_dec = 1'b1;
            state_d = trac_pkg::ST_WAIT;
          end
        end
      end
      trac_pkg::ST_AUTO: begin
        if (!touched_i) begin
          inc_dec = 1'b1;
          state_d = trac_pkg::ST_WAIT;
        end else if (auto_q == cfg_i.auto_delay_ticks) begin
          clr     = 1'b1;
          inc_dec = 1'b1;
          state_d = trac_pkg::ST_RATE_RUN;
        end
      end
      trac_pkg::ST_RATE_RUN: begin
        if (!touched_i) begin
          state_d = trac_pkg::ST_WAIT;
        end else if (rate_q == cfg_i.repeat_ticks) begin
          clr     = 1'b1;
          state_d = trac_pkg::ST_RATE_EXP;
        end
      end
      trac_pkg::ST_RATE_EXP: begin
        if (touched_i) begin
          inc_dec = 1'b1;
          state_d = trac_pkg::ST_RATE_RUN;
        end else begin
          state_d = trac_pkg::ST_WAIT;
        end
      end
      default: state_d = trac_pkg::ST_NEVER;
    endcase
  end

  // Apply the action of the new state to the hold counters.
  always_comb begin
    settle_d = settle_q;
    auto_d   = auto_q;
    rate_d   = rate_q;
    unique case (state_d)
      trac_pkg::ST_WAIT: begin
        settle_d = '0;
        auto_d   = '0;
        rate_d   = '0;
      end
      trac_pkg::ST_SETTLE:   settle_d = settle_q + 1'b1;
      trac_pkg::ST_AUTO:     auto_d   = auto_q + 1'b1;
      trac_pkg::ST_RATE_RUN: rate_d   = rate_q + 1'b1;
      trac_pkg::ST_RATE_EXP: rate_d   = '0;
      default: ;
    endcase
  end

  // Count ticks toward one second once the first touch has been seen.
  assign subsec_inc = {1'b0, subsec_q} + 1'b1;
  always_comb begin
    adv      = 1'b0;
    subsec_d = subsec_q;
    if (state_d != trac_pkg::ST_INIT && state_d != trac_pkg::ST_NEVER) begin
      if (subsec_inc >= {1'b0, cfg_i.ticks_per_second}) begin
        adv      = 1'b1;
        subsec_d = '0;
      end else begin
        subsec_d = subsec_inc[trac_pkg::SubSecW-1:0];
      end
    end
  end

  // Advance all state only when a request is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= trac_pkg::ST_INIT;
      settle_q <= '0;
      auto_q   <= '0;
      rate_q   <= '0;
      subsec_q <= '0;
    end else if (step_i) begin
      state_q  <= state_d;
      settle_q <= settle_d;
      auto_q   <= auto_d;
      rate_q   <= rate_d;
      subsec_q <= subsec_d;
    end
  end

  assign result_o.inc_dec_pulse     = inc_dec;
  assign result_o.clear_touch_pulse = clr;
  assign result_o.advance_second    = adv;
  assign result_o.state_code        = state_d;

  `TRAC_ASSERT_SAME(a_both_pulses_enter_rate, step_i && inc_dec && clr,
                    state_d == trac_pkg::ST_RATE_RUN, "inc/dec with clear outside rate entry")
  `TRAC_ASSERT_NEXT(a_wait_clears_counts, step_i && state_d == trac_pkg::ST_WAIT,
                    settle_q == '0 && auto_q == '0 && rate_q == '0,
                    "hold counters not cleared in waiting")
  `TRAC_ASSERT_NEXT(a_second_wraps, step_i && adv, subsec_q == '0,
                    "sub-second counter not wrapped on advance")
  `TRAC_ASSERT_SAME(a_init_leaves, state_q == trac_pkg::ST_INIT,
                    state_d == trac_pkg::ST_NEVER && !inc_dec && !clr && !adv,
                    "init must go quietly to never touched")

endmodule

// ===== rtl/touch_auto_repeat_clock_control.sv =====
// Top level: request and result registers around the touch control core.
//
// Touch auto-repeat clock control. Each input request is one tick carrying
// the touch level; each produces exactly one result with the inc/dec,
// clear-touch and advance-second pulses and the new state code. A request
// is captured in an input register and processed into the result register
// when the result register is free, so the block sustains one tick per clock
// cycle while results are taken as offered. The next state, the hold
// counters and the sub-second wrap form one short combinational step
// between those registers. A waiting result lets the input register take
// one more request, after which the input stalls until the result is taken.
// The four limits are set over the APB port at byte addresses 0, 4, 8 and
// 12 and should be written only while no tick is in flight.
module touch_auto_repeat_clock_control (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       touched_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       inc_dec_pulse_o,
  output logic                       clear_touch_pulse_o,
  output logic                       advance_second_o,
  output logic [2:0]                 state_code_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [trac_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  trac_pkg::cfg_t    cfg;
  trac_pkg::result_t core_res;
  trac_pkg::result_t res_q;
  logic              in_valid_q, touched_q;
  logic              out_valid_q;
  logic              step;

  trac_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Process the held request whenever the result register is free.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  trac_ctrl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .touched_i(touched_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  // Hold the incoming request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      touched_q <= touched_i;
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign inc_dec_pulse_o     = res_q.inc_dec_pulse;
  assign clear_touch_pulse_o = res_q.clear_touch_pulse;
  assign advance_second_o    = res_q.advance_second;
  assign state_code_o        = res_q.state_code;

endmodule
